// File: sv/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

  localparam int MAX_DELIM_DEF   = 8;
  localparam int DELIM_REG_BYTES = 8;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 32;
  localparam int LEN_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = DELIM_REG_BYTES * BYTE_W;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_LENGTH = 1'b0,
    REG_DELIM_BYTES  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_length;
    logic             final_segment;
  } seg_t;

  // up to two results written in one cycle, seg_a first
  typedef struct packed {
    logic [1:0] num;
    seg_t       seg_a;
    seg_t       seg_b;
  } push_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + POS_W'(1);
  endfunction

endpackage

// File: sv/dss_if.sv
`timescale 1ns / 1ps

interface dss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_byte;
  logic       end_of_string;

  modport source (output valid, char_byte, has_byte, end_of_string, input ready);
  modport sink   (input valid, char_byte, has_byte, end_of_string, output ready);
endinterface

interface dss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] seg_start;
  logic [31:0] seg_length;
  logic        final_segment;

  modport source (output valid, seg_start, seg_length, final_segment, input ready);
  modport sink   (input valid, seg_start, seg_length, final_segment, output ready);
endinterface

// File: sv/delimiter_string_split_core.sv
`timescale 1ns / 1ps
// results are registered into the result queue on the input transfer that causes them
// one input item per cycle while the queue has room; an item that yields both a
//   match and a closing segment sends them one at a time through the single result port
// a four-entry result queue decouples the sides; input stalls when fewer than two
//   entries are free
// reset (rst_n, synchronous, active low) clears registers, positions, history and queue

module delimiter_string_split_core #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dss_in_if.sink                          in_ch,
  dss_out_if.source                       out_ch
);
  import dss_pkg::*;

  // usable delimiter length and history depth
  localparam int LIM  = (MAX_DELIM < DELIM_REG_BYTES) ? MAX_DELIM : DELIM_REG_BYTES;
  localparam int HIST = (LIM > 1) ? LIM - 1 : 1;

  // configuration registers
  logic [LEN_W-1:0]      delim_length_r, delim_length_nxt;
  logic [CFG_DATA_W-1:0] delim_bytes_r, delim_bytes_nxt;

  // string state
  logic [HIST-1:0][7:0]  hist_r, hist_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      seg_beg_r, seg_beg_nxt;

  logic                  accept;
  logic                  space_ok;
  logic                  hit;
  logic [LEN_W-1:0]      eff_len;
  logic [POS_W:0]        idx_p1;
  logic [POS_W-1:0]      match_start;
  push_t                 push;
  seg_t                  close_seg;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && in_ch.ready;

  // register writes
  always_comb begin
    delim_length_nxt = delim_length_r;
    delim_bytes_nxt  = delim_bytes_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELIM_LENGTH: delim_length_nxt = cfg_wdata[LEN_W-1:0];
        REG_DELIM_BYTES:  delim_bytes_nxt  = cfg_wdata;
        default:          ;
      endcase
    end
  end

  // lengths beyond the window clamp to it
  assign eff_len = (delim_length_r > LEN_W'(LIM)) ? LEN_W'(LIM) : delim_length_r;

  dss_match #(
    .MAX_DELIM (MAX_DELIM)
  ) u_match (
    .char_byte   (in_ch.char_byte),
    .hist        (hist_r),
    .delim_bytes (delim_bytes_r),
    .eff_len     (eff_len),
    .hit         (hit)
  );

  assign idx_p1      = {1'b0, pos_r} + (POS_W+1)'(1);
  assign match_start = POS_W'(idx_p1 - (POS_W+1)'(eff_len));

  // per item update: match segment first, then the closing segment
  always_comb begin
    hist_nxt    = hist_r;
    pos_nxt     = pos_r;
    seg_beg_nxt = seg_beg_r;
    push        = '0;
    close_seg   = '0;

    if (accept && in_ch.has_byte) begin
      // window must lie inside the current string, so stale bytes never count
      if (eff_len != '0 && idx_p1 >= (POS_W+1)'(eff_len) && hit) begin
        // no overlap with the previous accepted delimiter
        if (match_start >= seg_beg_r) begin
          push.num                 = 2'd1;
          push.seg_a.seg_start     = seg_beg_r;
          push.seg_a.seg_length    = match_start - seg_beg_r;
          push.seg_a.final_segment = 1'b0;
          seg_beg_nxt              = sat_inc(pos_r);
        end
      end
      hist_nxt[0] = in_ch.char_byte;
      for (int i = 1; i < HIST; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      pos_nxt = sat_inc(pos_r);
    end

    if (accept && in_ch.end_of_string) begin
      close_seg.seg_start     = seg_beg_nxt;
      close_seg.seg_length    = (pos_nxt >= seg_beg_nxt) ? pos_nxt - seg_beg_nxt : '0;
      close_seg.final_segment = 1'b1;
      if (push.num == 2'd0) begin
        push.seg_a = close_seg;
      end else begin
        push.seg_b = close_seg;
      end
      push.num    = push.num + 2'd1;
      pos_nxt     = '0;
      seg_beg_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_length_r <= '0;
      delim_bytes_r  <= '0;
      hist_r         <= '0;
      pos_r          <= '0;
      seg_beg_r      <= '0;
    end else begin
      delim_length_r <= delim_length_nxt;
      delim_bytes_r  <= delim_bytes_nxt;
      hist_r         <= hist_nxt;
      pos_r          <= pos_nxt;
      seg_beg_r      <= seg_beg_nxt;
    end
  end

  // result queue drives the output channel
  dss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

// File: sv/dss_match.sv
`timescale 1ns / 1ps

module dss_match #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF,
  localparam int LIM  = (MAX_DELIM < dss_pkg::DELIM_REG_BYTES) ? MAX_DELIM
                                                               : dss_pkg::DELIM_REG_BYTES,
  localparam int HIST = (LIM > 1) ? LIM - 1 : 1
) (
  input  logic [7:0]                      char_byte,
  input  logic [HIST-1:0][7:0]            hist,
  input  logic [dss_pkg::CFG_DATA_W-1:0]  delim_bytes,
  input  logic [dss_pkg::LEN_W-1:0]       eff_len,
  output logic                            hit
);
  import dss_pkg::*;

  logic [LIM-1:0][7:0] win;
  logic [LIM-1:0]      match_d;

  // win[0] is the newest byte
  always_comb begin
    win[0] = char_byte;
    for (int i = 1; i < LIM; i++) begin
      win[i] = hist[i-1];
    end
  end

  // one comparator row per delimiter length
  always_comb begin
    for (int d = 1; d <= LIM; d++) begin
      match_d[d-1] = 1'b1;
      for (int k = 0; k < d; k++) begin
        if (win[d-1-k] != delim_bytes[BYTE_W*k +: BYTE_W]) begin
          match_d[d-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int d = 1; d <= LIM; d++) begin
      if (eff_len == LEN_W'(d)) begin
        hit = match_d[d-1];
      end
    end
  end

endmodule

// File: sv/dss_queue.sv
`timescale 1ns / 1ps

module dss_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  dss_pkg::push_t  push,
  output logic            space_ok,
  dss_out_if.source       out_ch
);
  import dss_pkg::*;

  seg_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;
  seg_t              head;

  assign pop      = out_ch.valid && out_ch.ready;
  assign space_ok = (cnt_r <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.num);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_r + QCNT_W'(push.num) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.seg_a;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= push.seg_b;
    end
  end

  assign head                 = mem_r[rd_ptr_r];
  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.seg_start     = head.seg_start;
  assign out_ch.seg_length    = head.seg_length;
  assign out_ch.final_segment = head.final_segment;

endmodule

// File: sv/dss_chk.sv
`timescale 1ns / 1ps

module dss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] seg_start,
  input logic [31:0] seg_length,
  input logic        final_segment
);

  // queue comes up empty with room for input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  // input only stalls behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // an empty queue only fills from an input transfer on the edge before
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result offered without a preceding input transfer");

  // pending result holds while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(seg_start)
                                && $stable(seg_length) && $stable(final_segment))
    else $error("result changed while stalled");

endmodule

bind delimiter_string_split_core dss_chk u_dss_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .seg_start     (out_ch.seg_start),
  .seg_length    (out_ch.seg_length),
  .final_segment (out_ch.final_segment)
);
